/* rtl/core/mmma_pkg.sv */
// Shared types and constants for the min/max/mean statistics block.
// Used by the controller, the datapath and the divider. No dependencies.
package mmma_pkg;

   localparam int SUM_W   = 56;
   localparam int DIV_W   = 32;
   localparam int VAL_W   = 32;
   localparam int MASK_W  = 16;
   localparam int ELAP_W  = 17;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_W   = 16;

   localparam logic [1:0] KIND_MEAN  = 2'd0;
   localparam logic [1:0] KIND_MAX   = 2'd1;
   localparam logic [1:0] KIND_MIN   = 2'd2;
   localparam logic [1:0] KIND_ERROR = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_METRIC_COUNT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INTERVAL     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OVER_TIME    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_REPORT   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_REPORT   = 3'd4;

   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_TICK   = 1'b1;

   typedef struct packed {
      logic       update;      // read-modify-write of the sampled entry
      logic       walk_start;  // reset walk pointer, clear elapsed
      logic       walk_next;   // advance walk pointer
      logic       clear;       // zero the walked entry
      logic       div_start;
      logic       push;        // new result into the pending slot
      logic [1:0] push_kind;
      logic       finish;      // release pending result as last of run
   } mmma_cmd_type;

   typedef struct packed {
      logic is_error;
      logic flush_due;
      logic skip;
      logic rep_max;
      logic rep_min;
      logic last_entry;
      logic div_busy;
      logic can_push;
      logic pend_valid;
      logic out_free;
   } mmma_status_type;

endpackage

/* rtl/core/mmma_div.sv */
// Iterative signed-by-unsigned divider, one quotient bit per cycle.
// Truncates toward zero and saturates to 32-bit signed. Uses mmma_pkg.
module mmma_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic signed [mmma_pkg::SUM_W-1:0] dividend,
   input  logic [mmma_pkg::DIV_W-1:0]       divisor,
   output logic                             busy,
   output logic signed [mmma_pkg::VAL_W-1:0] quotient
);
   import mmma_pkg::*;

   localparam int STEP_W = $clog2(SUM_W + 1);

   logic                busy_ff, busy_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic                neg_ff, neg_in;
   logic [SUM_W-1:0]    num_ff, num_in;
   logic [DIV_W-1:0]    rem_ff, rem_in;
   logic [DIV_W-1:0]    den_ff, den_in;
   logic [VAL_W-1:0]    quot_ff, quot_in;

   logic [DIV_W:0]      rem_sh;
   logic [DIV_W+1:0]    trial;
   logic                ge;

   always_comb begin
      rem_sh  = {rem_ff, num_ff[SUM_W-1]};
      trial   = {1'b0, rem_sh} - {2'b00, den_ff};
      ge      = !trial[DIV_W+1];
      busy_in = busy_ff;
      step_in = step_ff;
      neg_in  = neg_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quot_in = quot_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(SUM_W);
         neg_in  = dividend[SUM_W-1];
         num_in  = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
         rem_in  = '0;
         den_in  = divisor;
      end else if (busy_ff) begin
         if (step_ff != '0) begin
            step_in = step_ff - STEP_W'(1);
            rem_in  = ge ? trial[DIV_W-1:0] : rem_sh[DIV_W-1:0];
            num_in  = {num_ff[SUM_W-2:0], ge};
         end else begin
            busy_in = 1'b0;
            if (!neg_ff) begin
               quot_in = (num_ff > SUM_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF
                                                         : num_ff[VAL_W-1:0];
            end else begin
               quot_in = (num_ff > SUM_W'(32'h8000_0000)) ? 32'h8000_0000
                                                         : (~num_ff[VAL_W-1:0]) + 32'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
      neg_ff  <= neg_in;
      num_ff  <= num_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
   end

   assign busy     = busy_ff;
   assign quotient = quot_ff;

endmodule

/* rtl/core/mmma_datapath.sv */
// Datapath: configuration registers, per-metric tables, elapsed counter,
// divider, pending result slot and output register. Uses mmma_pkg, mmma_div.
module mmma_datapath #(
   parameter int STAT_SLOTS = 16,
   parameter int COUNT_BITS = 24
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_enable,
   input  logic [mmma_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [mmma_pkg::CSR_W-1:0]         csr_write_data,
   input  logic                               req_accept,
   input  logic                               req_command,
   input  logic [7:0]                         req_metric_index,
   input  logic signed [mmma_pkg::VAL_W-1:0]  req_sample_value,
   input  mmma_pkg::mmma_cmd_type             cmd,
   output mmma_pkg::mmma_status_type          status,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [7:0]                         rsp_report_metric,
   output logic [1:0]                         rsp_report_kind,
   output logic signed [mmma_pkg::VAL_W-1:0]  rsp_report_value,
   output logic                               rsp_last_of_run
);
   import mmma_pkg::*;

   localparam int IDX_W = (STAT_SLOTS > 1) ? $clog2(STAT_SLOTS) : 1;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
   localparam logic signed [SUM_W:0] SUM_HI = (SUM_W+1)'({1'b0, {(SUM_W-1){1'b1}}});
   localparam logic signed [SUM_W:0] SUM_LO = -SUM_HI - (SUM_W+1)'(1);

   // configuration
   logic [4:0]        metric_count_ff;
   logic [15:0]       interval_ff;
   logic [MASK_W-1:0] over_time_ff, max_rep_ff, min_rep_ff;

   // tables
   logic signed [SUM_W-1:0] sum_ff [STAT_SLOTS];
   logic [COUNT_BITS-1:0]   cnt_ff [STAT_SLOTS];
   logic signed [VAL_W-1:0] min_ff [STAT_SLOTS];
   logic signed [VAL_W-1:0] max_ff [STAT_SLOTS];
   logic [ELAP_W-1:0]       elapsed_ff;

   logic [7:0]              idx_ff;
   logic signed [VAL_W-1:0] val_ff;
   logic [IDX_W-1:0]        walk_ff;

   // pending and output slots
   logic              pend_valid_ff;
   logic [7:0]        pend_metric_ff;
   logic [1:0]        pend_kind_ff;
   logic [VAL_W-1:0]  pend_value_ff;
   logic              out_valid_ff;
   logic [7:0]        out_metric_ff;
   logic [1:0]        out_kind_ff;
   logic [VAL_W-1:0]  out_value_ff;
   logic              out_last_ff;

   logic [4:0]              used;
   logic [IDX_W-1:0]        addr;
   logic signed [SUM_W-1:0] rd_sum;
   logic [COUNT_BITS-1:0]   rd_cnt;
   logic signed [VAL_W-1:0] rd_min, rd_max, first_min, first_max;
   logic signed [SUM_W:0]   sum_wide;
   logic signed [SUM_W-1:0] sum_in;
   logic signed [VAL_W-1:0] min_in, max_in;
   logic [COUNT_BITS-1:0]   cnt_in;
   logic                    timed;
   logic [DIV_W-1:0]        divisor;
   logic                    div_busy;
   logic signed [VAL_W-1:0] quotient;
   logic                    out_free, can_push;
   logic [7:0]              push_metric;
   logic [VAL_W-1:0]        push_value;

   assign used = (metric_count_ff < 5'(STAT_SLOTS)) ? metric_count_ff : 5'(STAT_SLOTS);
   assign addr = cmd.update ? idx_ff[IDX_W-1:0] : walk_ff;

   always_comb begin
      rd_sum    = sum_ff[addr];
      rd_cnt    = cnt_ff[addr];
      rd_min    = min_ff[addr];
      rd_max    = max_ff[addr];
      first_min = (rd_cnt == '0) ? val_ff : rd_min;
      first_max = (rd_cnt == '0) ? val_ff : rd_max;
      sum_wide  = {rd_sum[SUM_W-1], rd_sum} + (SUM_W+1)'(val_ff);
      if (sum_wide > SUM_HI)      sum_in = SUM_HI[SUM_W-1:0];
      else if (sum_wide < SUM_LO) sum_in = SUM_LO[SUM_W-1:0];
      else                        sum_in = sum_wide[SUM_W-1:0];
      cnt_in = (rd_cnt < COUNT_MAX) ? rd_cnt + COUNT_BITS'(1) : rd_cnt;
      max_in = first_max;
      min_in = first_min;
      if (val_ff > first_max)      max_in = val_ff;
      else if (val_ff < first_min) min_in = val_ff;
   end

   assign timed   = over_time_ff[walk_ff];
   assign divisor = timed ? ((interval_ff == '0) ? DIV_W'(1) : DIV_W'(interval_ff))
                          : DIV_W'(rd_cnt);

   mmma_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (rd_sum),
      .divisor  (divisor),
      .busy     (div_busy),
      .quotient (quotient)
   );

   assign out_free = !out_valid_ff || !rsp_stall;
   assign can_push = !pend_valid_ff || out_free;

   always_comb begin
      push_metric = 8'(walk_ff);
      case (cmd.push_kind)
         KIND_MEAN:  push_value = quotient;
         KIND_MAX:   push_value = rd_max;
         KIND_MIN:   push_value = rd_min;
         default: begin
            push_metric = idx_ff;
            push_value  = '0;
         end
      endcase
   end

   always_comb begin
      status.is_error   = idx_ff >= {3'b000, used};
      status.flush_due  = elapsed_ff > {1'b0, interval_ff};
      status.skip       = !timed && (rd_cnt == '0);
      status.rep_max    = max_rep_ff[walk_ff];
      status.rep_min    = min_rep_ff[walk_ff];
      status.last_entry = (5'(walk_ff) + 5'd1) >= used;
      status.div_busy   = div_busy;
      status.can_push   = can_push;
      status.pend_valid = pend_valid_ff;
      status.out_free   = out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         metric_count_ff <= 5'd16;
         interval_ff     <= 16'd1;
         over_time_ff    <= '0;
         max_rep_ff      <= '0;
         min_rep_ff      <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_METRIC_COUNT: metric_count_ff <= csr_write_data[4:0];
            CSR_INTERVAL:     interval_ff     <= csr_write_data;
            CSR_OVER_TIME:    over_time_ff    <= csr_write_data;
            CSR_MAX_REPORT:   max_rep_ff      <= csr_write_data;
            CSR_MIN_REPORT:   min_rep_ff      <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < STAT_SLOTS; i++) begin
            sum_ff[i] <= '0;
            cnt_ff[i] <= '0;
            min_ff[i] <= '0;
            max_ff[i] <= '0;
         end
         elapsed_ff <= '0;
         walk_ff    <= '0;
      end else begin
         if (cmd.update) begin
            sum_ff[addr] <= sum_in;
            cnt_ff[addr] <= cnt_in;
            min_ff[addr] <= min_in;
            max_ff[addr] <= max_in;
         end else if (cmd.clear) begin
            sum_ff[addr] <= '0;
            cnt_ff[addr] <= '0;
            min_ff[addr] <= '0;
            max_ff[addr] <= '0;
         end
         if (cmd.walk_start) begin
            elapsed_ff <= '0;
            walk_ff    <= '0;
         end else begin
            if (req_accept && req_command == CMD_TICK && elapsed_ff != '1)
               elapsed_ff <= elapsed_ff + ELAP_W'(1);
            if (cmd.walk_next)
               walk_ff <= walk_ff + IDX_W'(1);
         end
      end
   end

   // hold the item for the update cycle
   always_ff @(posedge clock) begin
      if (req_accept) begin
         idx_ff <= req_metric_index;
         val_ff <= req_sample_value;
      end
   end

   // one result waits in the pending slot so the last one can be flagged
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (out_valid_ff && !rsp_stall)
            out_valid_ff <= 1'b0;
         if ((cmd.push || cmd.finish) && pend_valid_ff)
            out_valid_ff <= 1'b1;
         if (cmd.push)
            pend_valid_ff <= 1'b1;
         else if (cmd.finish)
            pend_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if ((cmd.push || cmd.finish) && pend_valid_ff) begin
         out_metric_ff <= pend_metric_ff;
         out_kind_ff   <= pend_kind_ff;
         out_value_ff  <= pend_value_ff;
         out_last_ff   <= cmd.finish;
      end
      if (cmd.push) begin
         pend_metric_ff <= push_metric;
         pend_kind_ff   <= cmd.push_kind;
         pend_value_ff  <= push_value;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_report_metric = out_metric_ff;
   assign rsp_report_kind   = out_kind_ff;
   assign rsp_report_value  = out_value_ff;
   assign rsp_last_of_run   = out_last_ff;

endmodule

/* rtl/core/mmma_ctrl.sv */
// Controller state machine: sample update, error report and flush walk.
// Drives datapath commands from its status. Uses mmma_pkg.
module mmma_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_command,
   output logic                      req_stall,
   input  mmma_pkg::mmma_status_type status,
   output mmma_pkg::mmma_cmd_type    cmd
);
   import mmma_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_SAMPLE, S_WALK, S_DIV, S_MEAN, S_MAX, S_MIN, S_CLR, S_FINISH
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && req_command == CMD_SAMPLE) state_in = S_SAMPLE;
         end
         S_SAMPLE: begin
            if (status.is_error) begin
               cmd.push      = 1'b1;
               cmd.push_kind = KIND_ERROR;
               state_in      = S_FINISH;
            end else begin
               cmd.update = 1'b1;
               if (status.flush_due) begin
                  cmd.walk_start = 1'b1;
                  state_in       = S_WALK;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_WALK: begin
            if (status.skip) begin
               state_in = S_CLR;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = S_DIV;
            end
         end
         S_DIV: begin
            if (!status.div_busy) state_in = S_MEAN;
         end
         S_MEAN: begin
            if (status.can_push) begin
               cmd.push      = 1'b1;
               cmd.push_kind = KIND_MEAN;
               state_in      = S_MAX;
            end
         end
         S_MAX: begin
            if (!status.rep_max) begin
               state_in = S_MIN;
            end else if (status.can_push) begin
               cmd.push      = 1'b1;
               cmd.push_kind = KIND_MAX;
               state_in      = S_MIN;
            end
         end
         S_MIN: begin
            if (!status.rep_min) begin
               state_in = S_CLR;
            end else if (status.can_push) begin
               cmd.push      = 1'b1;
               cmd.push_kind = KIND_MIN;
               state_in      = S_CLR;
            end
         end
         S_CLR: begin
            cmd.clear = 1'b1;
            if (status.last_entry) begin
               state_in = S_FINISH;
            end else begin
               cmd.walk_next = 1'b1;
               state_in      = S_WALK;
            end
         end
         S_FINISH: begin
            if (!status.pend_valid) begin
               state_in = S_IDLE;
            end else if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

   assign req_stall = (state_ff != S_IDLE);

endmodule

/* rtl/core/metric_min_max_mean_aggregator_core.sv */
// Per-metric min/max/mean statistics accumulator, top level.
// Tick: accept only, no stall. Sample: accept, then table read-modify-write.
// Index error: accept, pending slot, release, plus output stalls.
// Flush per reported entry: set by the bit-serial divider (56 steps, start and
// finish) and the walk states; skipped entries only walk and clear; plus output stalls.
// Synchronous active-high reset restores register defaults and zeroes tables.
module metric_min_max_mean_aggregator_core #(
   parameter int STAT_SLOTS = 16,
   parameter int COUNT_BITS = 24
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_enable,
   input  logic [mmma_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [mmma_pkg::CSR_W-1:0]        csr_write_data,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_command,
   input  logic [7:0]                        req_metric_index,
   input  logic signed [mmma_pkg::VAL_W-1:0] req_sample_value,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [7:0]                        rsp_report_metric,
   output logic [1:0]                        rsp_report_kind,
   output logic signed [mmma_pkg::VAL_W-1:0] rsp_report_value,
   output logic                              rsp_last_of_run
);
   import mmma_pkg::*;

   mmma_cmd_type    cmd;
   mmma_status_type status;
   logic            req_accept;

   assign req_accept = req_valid && !req_stall;

   mmma_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_command),
      .req_stall   (req_stall),
      .status      (status),
      .cmd         (cmd)
   );

   mmma_datapath #(
      .STAT_SLOTS (STAT_SLOTS),
      .COUNT_BITS (COUNT_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .req_accept        (req_accept),
      .req_command       (req_command),
      .req_metric_index  (req_metric_index),
      .req_sample_value  (req_sample_value),
      .cmd               (cmd),
      .status            (status),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_report_metric (rsp_report_metric),
      .rsp_report_kind   (rsp_report_kind),
      .rsp_report_value  (rsp_report_value),
      .rsp_last_of_run   (rsp_last_of_run)
   );

endmodule

/* bench/tb.sv */
// Self-checking bench for metric_min_max_mean_aggregator_core: drives samples and
// ticks, predicts every report in the bench itself and compares them in order.
// Depends on mmma_pkg and the core RTL only.
module tb;
   import mmma_pkg::*;

   localparam int STAT_SLOTS = 16;
   localparam int COUNT_BITS  = 24;
   localparam int CYCLE_LIMIT = 1500000;
   localparam int SETTLE_CYCLES = 120;
   localparam longint SUM_HI = 64'sh007F_FFFF_FFFF_FFFF;
   localparam longint SUM_LO = -SUM_HI - 1;
   localparam int unsigned ELAPSED_TOP = 17'h1FFFF;
   localparam longint unsigned COUNT_TOP = (64'd1 << COUNT_BITS) - 1;

   typedef struct {
      logic [7:0]         metric;
      logic [1:0]         kind;
      logic signed [31:0] value;
      logic               last;
   } report_type;

   logic                clock = 1'b0;
   logic                reset;
   logic                csr_write_enable;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]    csr_write_data;
   logic                req_valid;
   logic                req_stall;
   logic                req_command;
   logic [7:0]          req_metric_index;
   logic signed [31:0]  req_sample_value;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [7:0]          rsp_report_metric;
   logic [1:0]          rsp_report_kind;
   logic signed [31:0]  rsp_report_value;
   logic                rsp_last_of_run;

   metric_min_max_mean_aggregator_core #(
      .STAT_SLOTS (STAT_SLOTS),
      .COUNT_BITS (COUNT_BITS)
   ) dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predicted block state
   longint          sum_tab [STAT_SLOTS];
   longint unsigned count_tab [STAT_SLOTS];
   int              min_tab [STAT_SLOTS];
   int              max_tab [STAT_SLOTS];
   int unsigned     elapsed;
   int unsigned     cfg_metric_count;
   int unsigned     cfg_interval;
   logic [15:0]     cfg_over_time;
   logic [15:0]     cfg_max_report;
   logic [15:0]     cfg_min_report;

   report_type pending_reports[$];
   int      failures = 0;
   int      hold_left = 0;
   int      burst_left = 0;
   int      cycles = 0;

   function automatic int sat32(longint v);
      if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'sh8000_0000;
      return int'(v);
   endfunction

   function automatic void clear_stats();
      for (int i = 0; i < STAT_SLOTS; i++) begin
         sum_tab[i] = 0;
         count_tab[i] = 0;
         min_tab[i] = 0;
         max_tab[i] = 0;
      end
      elapsed = 0;
   endfunction

   // work out the reports one accepted transfer causes
   function automatic void predict_reports(logic cmd, logic [7:0] idx, int val);
      int unsigned used;
      report_type  run[$];
      report_type  r;
      longint      s;
      longint      div;
      used = (cfg_metric_count < STAT_SLOTS) ? cfg_metric_count : STAT_SLOTS;
      if (cmd == CMD_TICK) begin
         if (elapsed < ELAPSED_TOP) elapsed++;
         return;
      end
      if (idx >= used) begin
         r = '{metric: idx, kind: KIND_ERROR, value: 0, last: 1'b1};
         pending_reports.push_back(r);
         return;
      end
      if (count_tab[idx] == 0) begin
         min_tab[idx] = val;
         max_tab[idx] = val;
      end
      s = sum_tab[idx] + longint'(val);
      if (s > SUM_HI) s = SUM_HI;
      if (s < SUM_LO) s = SUM_LO;
      sum_tab[idx] = s;
      if (count_tab[idx] < COUNT_TOP) count_tab[idx]++;
      if (val > max_tab[idx]) max_tab[idx] = val;
      else if (val < min_tab[idx]) min_tab[idx] = val;
      if (elapsed <= cfg_interval) return;
      for (int i = 0; i < used; i++) begin
         if (cfg_over_time[i]) begin
            div = (cfg_interval != 0) ? longint'(cfg_interval) : 1;
         end else begin
            if (count_tab[i] == 0) continue;
            div = longint'(count_tab[i]);
         end
         run.push_back('{metric: 8'(i), kind: KIND_MEAN,
                         value: sat32(sum_tab[i] / div), last: 1'b0});
         if (cfg_max_report[i])
            run.push_back('{metric: 8'(i), kind: KIND_MAX, value: max_tab[i], last: 1'b0});
         if (cfg_min_report[i])
            run.push_back('{metric: 8'(i), kind: KIND_MIN, value: min_tab[i], last: 1'b0});
         sum_tab[i] = 0;
         count_tab[i] = 0;
         min_tab[i] = 0;
         max_tab[i] = 0;
      end
      elapsed = 0;
      if (run.size() > 0) run[run.size()-1].last = 1'b1;
      foreach (run[k]) pending_reports.push_back(run[k]);
   endfunction

   // result checker: a transfer happens at the next rising edge
   always @(negedge clock) begin
      report_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_reports.size() == 0) begin
            $error("unexpected report metric=%0d kind=%0d value=%0d",
                   rsp_report_metric, rsp_report_kind, rsp_report_value);
            failures++;
         end else begin
            e = pending_reports.pop_front();
            if (rsp_report_metric !== e.metric) begin
               $error("report_metric expected %0d got %0d", e.metric, rsp_report_metric);
               failures++;
            end
            if (rsp_report_kind !== e.kind) begin
               $error("report_kind expected %0d got %0d", e.kind, rsp_report_kind);
               failures++;
            end
            if (rsp_report_value !== e.value) begin
               $error("report_value expected %0d got %0d", e.value, rsp_report_value);
               failures++;
            end
            if (rsp_last_of_run !== e.last) begin
               $error("last_of_run expected %0d got %0d", e.last, rsp_last_of_run);
               failures++;
            end
         end
      end
   end

   // receiver stall pattern; a long hold-off overrides it
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else begin
         case ((cycles / 200) % 3)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            default: rsp_stall <= ($urandom_range(0, 9) < 6);
         endcase
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // offer one item; returns at the edge of its transfer with valid still high
   task automatic send_item(logic cmd, logic [7:0] idx, logic signed [31:0] val);
      logic stalled;
      req_valid <= 1'b1;
      req_command <= cmd;
      req_metric_index <= idx;
      req_sample_value <= val;
      do begin
         @(negedge clock);
         stalled = req_stall;
         @(posedge clock);
      end while (stalled);
      predict_reports(cmd, idx, val);
   endtask

   task automatic idle(int n);
      req_valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // bursts of random length with random gaps
   task automatic pace();
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         idle($urandom_range(1, 8));
         burst_left = $urandom_range(0, 12);
      end
   endtask

   task automatic wait_drain();
      idle(1);
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [15:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         CSR_METRIC_COUNT: cfg_metric_count = data[4:0];
         CSR_INTERVAL:     cfg_interval = data;
         CSR_OVER_TIME:    cfg_over_time = data;
         CSR_MAX_REPORT:   cfg_max_report = data;
         CSR_MIN_REPORT:   cfg_min_report = data;
         default: ;
      endcase
   endtask

   task automatic setup(logic [15:0] cnt, logic [15:0] intv, logic [15:0] otm,
                        logic [15:0] mxm, logic [15:0] mnm);
      write_reg(CSR_METRIC_COUNT, cnt);
      write_reg(CSR_INTERVAL, intv);
      write_reg(CSR_OVER_TIME, otm);
      write_reg(CSR_MAX_REPORT, mxm);
      write_reg(CSR_MIN_REPORT, mnm);
   endtask

   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(0, 5))
         0: return 32'sh7FFF_FFFF;
         1: return 32'sh8000_0000;
         2: return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
         default: return $urandom;
      endcase
   endfunction

   // defaults after reset: first sample sets min and max, flush after two ticks
   task automatic test_reset_defaults();
      send_item(CMD_SAMPLE, 8'd0, 32'sh0001_8000);
      send_item(CMD_SAMPLE, 8'd0, -32'sh0000_4000);
      send_item(CMD_SAMPLE, 8'd15, 32'sh7FFF_FFFF);
      send_item(CMD_SAMPLE, 8'd16, 32'sh0);
      send_item(CMD_SAMPLE, 8'd255, $urandom);
      send_item(CMD_TICK, 8'hFF, 32'sh8000_0000);
      send_item(CMD_TICK, 8'd0, 32'sh0);
      send_item(CMD_SAMPLE, 8'd3, 32'sh8000_0000);
      wait_drain();
   endtask

   // masks all set, time averages with saturated means, zero interval
   task automatic test_config_extremes();
      setup(16'd16, 16'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_item(CMD_SAMPLE, 8'd1, 32'sh7FFF_FFFF);
      send_item(CMD_SAMPLE, 8'd1, 32'sh7FFF_FFFF);
      send_item(CMD_SAMPLE, 8'd2, 32'sh8000_0000);
      send_item(CMD_SAMPLE, 8'd2, 32'sh8000_0000);
      send_item(CMD_TICK, 8'd0, 32'sh0);
      send_item(CMD_TICK, 8'd0, 32'sh0);
      send_item(CMD_SAMPLE, 8'd15, -32'sd3);
      wait_drain();
      setup(16'd5, 16'd0, 16'h0005, 16'h000A, 16'h0011);
      send_item(CMD_SAMPLE, 8'd4, 32'sd7);
      send_item(CMD_SAMPLE, 8'd4, -32'sd9);
      send_item(CMD_SAMPLE, 8'd5, 32'sd1);
      send_item(CMD_TICK, 8'd0, 32'sh0);
      send_item(CMD_SAMPLE, 8'd1, -32'sd5);
      wait_drain();
      setup(16'd0, 16'hFFFF, 16'h0, 16'h0, 16'h0);
      send_item(CMD_SAMPLE, 8'd0, 32'sd1);
      wait_drain();
      write_reg(CSR_METRIC_COUNT, 16'd31);
      send_item(CMD_SAMPLE, 8'd15, 32'sd2);
      send_item(CMD_SAMPLE, 8'd16, 32'sd2);
      wait_drain();
   endtask

   // elapsed count runs past a longer interval before the flush
   task automatic test_elapsed_flush();
      setup(16'd2, 16'd6, 16'h0002, 16'h0001, 16'h0002);
      send_item(CMD_SAMPLE, 8'd1, 32'sh0010_0000);
      for (int i = 0; i < 9; i++) send_item(CMD_TICK, 8'($urandom), $urandom);
      send_item(CMD_SAMPLE, 8'd0, -32'sh0001_0000);
      wait_drain();
   endtask

   task automatic random_items(int n);
      int r;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         if (r < 55)
            send_item(CMD_SAMPLE, 8'($urandom_range(0, 15)), pick_value());
         else if (r < 85)
            send_item(CMD_TICK, 8'($urandom), $urandom);
         else
            send_item(CMD_SAMPLE, 8'($urandom), pick_value());
         pace();
      end
   endtask

   task automatic test_random();
      setup(16'd16, 16'd2, 16'($urandom), 16'($urandom), 16'($urandom));
      random_items(10);
      wait_drain();
      setup(16'd1, 16'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      random_items(10);
      wait_drain();
      setup(16'($urandom_range(1, 16)), 16'($urandom_range(1, 5)), 16'($urandom),
            16'($urandom), 16'($urandom));
      random_items(10);
      wait_drain();
      setup(16'd7, 16'd0, 16'($urandom), 16'h0, 16'hFFFF);
      random_items(10);
      wait_drain();
   endtask

   // hold the receiver while flushes pile up, then pause until all drained
   task automatic test_backpressure();
      setup(16'd16, 16'd0, 16'h00FF, 16'hFFFF, 16'hFFFF);
      hold_left = 600;
      for (int i = 0; i < 15; i++) begin
         send_item(CMD_SAMPLE, 8'($urandom_range(0, 15)), pick_value());
         send_item(CMD_TICK, 8'd0, 32'sh0);
      end
      wait_drain();
   endtask

   initial begin
      reset <= 1'b1;
      csr_write_enable <= 1'b0;
      csr_index <= CSR_METRIC_COUNT;
      csr_write_data <= '0;
      req_valid <= 1'b0;
      req_command <= CMD_SAMPLE;
      req_metric_index <= '0;
      req_sample_value <= '0;
      clear_stats();
      cfg_metric_count = 16;
      cfg_interval = 1;
      cfg_over_time = '0;
      cfg_max_report = '0;
      cfg_min_report = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_config_extremes();
      test_elapsed_flush();
      test_random();
      test_backpressure();
      if (failures == 0 && pending_reports.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule
